// ===== src/aed_pkg.sv =====
// Shared types and constants for the audio echo / distortion effect core.
// No dependencies; compiled first.
package aed_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int STORE_DEPTH = 16384;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int DLY_W       = 15;
  localparam int EFF_W       = (CNT_W > DLY_W) ? CNT_W : DLY_W;
  localparam int FB_W        = 9;
  localparam int FB_ONE      = 256;
  localparam int PROD_W      = 33;
  localparam int ACC_W       = 25;
  localparam int Q_W         = 42;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] MODE_IDENT = 2'd0;
  localparam logic [1:0] MODE_DIST  = 2'd1;
  localparam logic [1:0] MODE_ECHO  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_GAIN     = 3'd1,
    REG_CLIP     = 3'd2,
    REG_VOLUME   = 3'd3,
    REG_FEEDBACK = 3'd4,
    REG_DELAY    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [15:0]      gain;
    logic [15:0]      clip_level;
    logic [15:0]      volume;
    logic [FB_W-1:0]  feedback;
    logic [DLY_W-1:0] delay_length;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    mode:         MODE_IDENT,
    gain:         16'd128,
    clip_level:   16'd32768,
    volume:       16'd256,
    feedback:     9'd128,
    delay_length: 15'd9600
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic finish;
  } cmd_t;

endpackage

// ===== src/aed_if.sv =====
// Valid/ready stream interfaces for the sample input and result channels.
// Depends on aed_pkg.
interface aed_in_if;
  import aed_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source(output valid, output sample_in, input ready);
  modport sink(input valid, input sample_in, output ready);
endinterface

interface aed_out_if;
  import aed_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  modport source(output valid, output sample_out, input ready);
  modport sink(input valid, input sample_out, output ready);
endinterface

// ===== src/aed_cfg_regs.sv =====
// Configuration register file; a valid write also restarts the echo fill.
// Depends on aed_pkg.
module aed_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [aed_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [aed_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output aed_pkg::cfg_t                  cfg,
  output logic                           cfg_clear
);
  import aed_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic hit;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (cfg_we) begin
      hit = 1'b1;
      unique case (cfg_idx)
        REG_MODE:     cfg_nxt.mode         = cfg_wdata[1:0];
        REG_GAIN:     cfg_nxt.gain         = cfg_wdata;
        REG_CLIP:     cfg_nxt.clip_level   = cfg_wdata;
        REG_VOLUME:   cfg_nxt.volume       = cfg_wdata;
        REG_FEEDBACK: cfg_nxt.feedback     = cfg_wdata[FB_W-1:0];
        REG_DELAY:    cfg_nxt.delay_length = cfg_wdata[DLY_W-1:0];
        default:      hit                  = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg       = cfg_r;
  assign cfg_clear = hit;

endmodule

// ===== src/aed_ctrl.sv =====
// Sequencer: steps one item through the multiply stages.
// Depends on aed_pkg.
module aed_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output logic          in_ready,
  output aed_pkg::cmd_t cmd
);
  import aed_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/aed_datapath.sv =====
// Sample datapath: multiply stages, echo ring store, output register.
// Depends on aed_pkg.
module aed_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aed_pkg::cfg_t                     cfg,
  input  logic                              cfg_clear,
  input  aed_pkg::cmd_t                     cmd,
  input  logic signed [aed_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [aed_pkg::SAMPLE_W-1:0] sample_out,
  output logic                              out_free
);
  import aed_pkg::*;

  localparam int TQ_W = Q_W - 16;
  localparam logic signed [TQ_W-1:0] TQ_MAX = TQ_W'(32767);
  localparam logic signed [TQ_W-1:0] TQ_MIN = -TQ_W'(32768);

  logic signed [SAMPLE_W-1:0] echo_mem_r [STORE_DEPTH];

  logic signed [SAMPLE_W-1:0] x_r, old_r, out_r;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [Q_W-1:0]      q_r, q_nxt;
  logic                       fill_r;
  logic                       out_valid_r;
  logic [PTR_W-1:0]           ptr_r, ptr_nxt;
  logic [CNT_W-1:0]           fill_cnt_r;

  logic [EFF_W-1:0]           dly_ext;
  logic [CNT_W-1:0]           eff_d, ptr_inc;
  logic [FB_W-1:0]            r_eff, omr;
  logic signed [FB_W:0]       r_s, omr_s;
  logic signed [16:0]         gain_s, vol_s;
  logic signed [PROD_W-1:0]   lim_s, nlim_s;
  logic signed [TQ_W-1:0]     tq;
  logic                       rnd;
  logic signed [SAMPLE_W-1:0] sat, y;
  logic                       is_echo, is_dist;

  always_comb begin
    is_echo = (cfg.mode == MODE_ECHO);
    is_dist = (cfg.mode == MODE_DIST);

    dly_ext = EFF_W'(cfg.delay_length);
    if (dly_ext == '0) begin
      eff_d = CNT_W'(1);
    end else if (dly_ext > EFF_W'(STORE_DEPTH)) begin
      eff_d = CNT_W'(STORE_DEPTH);
    end else begin
      eff_d = CNT_W'(dly_ext);
    end
    ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);
    ptr_nxt = (ptr_inc >= eff_d) ? '0 : ptr_inc[PTR_W-1:0];

    r_eff  = (cfg.feedback > FB_W'(FB_ONE)) ? FB_W'(FB_ONE) : cfg.feedback;
    omr    = FB_W'(FB_ONE) - r_eff;
    r_s    = $signed({1'b0, r_eff});
    omr_s  = $signed({1'b0, omr});
    gain_s = $signed({1'b0, cfg.gain});
    vol_s  = $signed({1'b0, cfg.volume});
    lim_s  = $signed(PROD_W'({cfg.clip_level, 8'd0}));
    nlim_s = -lim_s;

    // stage 1: pre-gain or direct-path weight
    if (is_echo) begin
      prod_nxt = x_r * omr_s;
    end else begin
      prod_nxt = x_r * gain_s;
    end

    // stage 2: add feedback path or clamp
    if (is_echo) begin
      acc_nxt = $signed(prod_r[ACC_W-1:0]) + (r_s * old_r);
    end else if (prod_r > lim_s) begin
      acc_nxt = lim_s[ACC_W-1:0];
    end else if (prod_r < nlim_s) begin
      acc_nxt = nlim_s[ACC_W-1:0];
    end else begin
      acc_nxt = prod_r[ACC_W-1:0];
    end

    // stage 3: volume
    q_nxt = acc_r * vol_s;

    // truncate toward zero, then saturate
    rnd = q_r[Q_W-1] && (|q_r[15:0]);
    tq  = $signed(q_r[Q_W-1:16]) + $signed({{(TQ_W-1){1'b0}}, rnd});
    if (tq > TQ_MAX) begin
      sat = 16'sh7FFF;
    end else if (tq < TQ_MIN) begin
      sat = 16'sh8000;
    end else begin
      sat = tq[SAMPLE_W-1:0];
    end

    y = (is_dist || (is_echo && !fill_r)) ? sat : x_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_r <= echo_mem_r[ptr_r];
    end
    if (cmd.finish && is_echo) begin
      echo_mem_r[ptr_r] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= sample_in;
      fill_r <= (fill_cnt_r < eff_d);
    end
    if (cmd.mul1) prod_r <= prod_nxt;
    if (cmd.mul2) acc_r  <= acc_nxt;
    if (cmd.mul3) q_r    <= q_nxt;
    if (cmd.finish) out_r <= y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      fill_cnt_r  <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_clear) begin
        ptr_r      <= '0;
        fill_cnt_r <= '0;
      end else if (cmd.finish && is_echo) begin
        ptr_r <= ptr_nxt;
        if (fill_cnt_r < eff_d) begin
          fill_cnt_r <= fill_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = out_r;
  assign out_free   = !out_valid_r || out_ready;

endmodule

// ===== src/audio_echo_distortion_effect_core.sv =====
// Top level of the audio effect core: identity, distortion or feedback echo.
// Depends on aed_pkg, aed_if, aed_cfg_regs, aed_ctrl, aed_datapath.
//
// Usage:
//   in_ch  : one signed 16-bit sample per item (valid/ready).
//   out_ch : one processed sample per item (valid/ready), held in an output
//            register until taken.
//   cfg_*  : write-only register port; write only while no item is in flight.
//            Any write to a defined index restarts the echo fill phase.
// Timing: an item passes through three multiply steps in sequence (states MUL1,
//   MUL2, MUL3), then waits in DONE until the output register is free; a new
//   item is accepted only after the last one finishes. in_ready is high only while the
//   sequencer is idle.
// Stall: an item may be accepted while the previous result waits; the
//   sequencer then holds its result until the output register frees up.
// Reset (synchronous, rst_n low): registers to defaults, ring pointer and fill
//   count to zero. The echo store is not cleared; the fill phase writes every
//   entry of the delay line before its stored value is used.
module audio_echo_distortion_effect_core (
  input  logic                           clk,
  input  logic                           rst_n,
  aed_in_if.sink                         in_ch,
  aed_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [aed_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [aed_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import aed_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cfg_clear;
  logic out_free;

  aed_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cfg_clear (cfg_clear)
  );

  aed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  aed_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_clear  (cfg_clear),
    .cmd        (cmd),
    .sample_in  (in_ch.sample_in),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .sample_out (out_ch.sample_out),
    .out_free   (out_free)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrites an untaken item");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.finish))
    else $error("output valid without a finished item");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one sequencer command at once");

endmodule
